@@ hdl/itp_pkg.sv @@
// Shared types, character codes and helpers for the infix-to-postfix converter.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package itp_pkg;

    localparam int STACK_DEPTH_DEF = 32;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_end;
    } itp_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       end_marker;
        logic       last;
    } itp_out_t;

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } itp_state_t;

    typedef enum logic [1:0] {
        SRC_TOP,
        SRC_CHAR,
        SRC_TERM
    } itp_src_t;

    typedef struct packed {
        logic     load;
        logic     push;
        logic     pop;
        logic     emit;
        itp_src_t emit_src;
        logic     emit_last;
    } itp_cmd_t;

    typedef struct packed {
        logic is_end;
        logic is_letter;
        logic is_lpar;
        logic is_rpar;
        logic empty;
        logic one;
        logic top_lpar;
        logic below_lpar;
        logic pops_top;
        logic pops_below;
        logic out_free;
    } itp_status_t;

    function automatic logic [1:0] prec_of(input logic [7:0] c);
        logic [1:0] p;
        begin
            case (c)
                CH_PLUS, CH_MINUS: p = 2'd1;
                CH_STAR, CH_SLASH: p = 2'd2;
                default:           p = 2'd0;
            endcase
            return p;
        end
    endfunction

    function automatic logic letter_of(input logic [7:0] c);
        begin
            return (c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]});
        end
    endfunction

endpackage

`default_nettype wire

@@ hdl/itp_ctrl.sv @@
// Controller for the infix-to-postfix converter: accepts a character, then
// sequences pops, pushes and emits. Depends on itp_pkg.
`default_nettype none

module itp_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                char_valid,
    output logic                     char_stall,
    input  wire itp_pkg::itp_status_t sts,
    output itp_pkg::itp_cmd_t        cmd
);
    import itp_pkg::*;

    itp_state_t state_reg;
    itp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.emit_src  = SRC_TOP;
        char_stall    = (state_reg != ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (char_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                if (sts.is_end)
                begin
                    // flush top first, terminator closes the expression
                    if (!sts.empty)
                    begin
                        if (sts.out_free)
                        begin
                            cmd.pop  = 1'b1;
                            cmd.emit = 1'b1;
                        end
                    end
                    else if (sts.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_src  = SRC_TERM;
                        cmd.emit_last = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else if (sts.is_letter)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_src  = SRC_CHAR;
                        cmd.emit_last = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else if (sts.is_lpar)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (sts.is_rpar)
                begin
                    if (sts.empty)
                        state_next = ST_IDLE;
                    else if (sts.top_lpar)
                    begin
                        cmd.pop    = 1'b1;   // discard the matching '('
                        state_next = ST_IDLE;
                    end
                    else if (sts.out_free)
                    begin
                        cmd.pop       = 1'b1;
                        cmd.emit      = 1'b1;
                        cmd.emit_last = sts.one || sts.below_lpar;
                    end
                end
                else
                begin
                    if (!sts.empty && sts.pops_top)
                    begin
                        if (sts.out_free)
                        begin
                            cmd.pop       = 1'b1;
                            cmd.emit      = 1'b1;
                            cmd.emit_last = sts.one || !sts.pops_below;
                        end
                    end
                    else
                    begin
                        cmd.push   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/itp_dpath.sv @@
// Datapath for the infix-to-postfix converter: input latch, operator stack
// (memory plus top/below registers), output register. Depends on itp_pkg.
`default_nettype none

module itp_dpath #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire itp_pkg::itp_in_t     char_data,
    input  wire itp_pkg::itp_cmd_t    cmd,
    output itp_pkg::itp_status_t      sts,
    output logic                      post_valid,
    input  wire logic                 post_stall,
    output itp_pkg::itp_out_t         post_data
);
    import itp_pkg::*;

    localparam int IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int COUNT_W = $clog2(STACK_DEPTH + 1);

    logic [7:0]         ch_reg;
    logic               end_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [7:0]         top_reg;
    logic [7:0]         below_reg;
    logic [7:0]         stack_mem [STACK_DEPTH];
    logic               full;
    logic               do_push;
    logic [COUNT_W-1:0] rd_count;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic               out_valid_reg;
    itp_out_t           out_data_reg;
    itp_out_t           emit_data;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg  <= char_data.ch;
            end_reg <= char_data.is_end;
        end
    end

    assign full    = (count_reg == COUNT_W'(STACK_DEPTH));
    assign do_push = cmd.push && !full;

    always_comb
    begin
        count_next = count_reg;
        if (do_push)
            count_next = count_reg + COUNT_W'(1);
        else if (cmd.pop)
            count_next = count_reg - COUNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // entry two below the current top becomes the new below after a pop
    assign rd_count = count_reg - COUNT_W'(3);
    assign rd_addr  = rd_count[IDX_W-1:0];
    assign wr_addr  = count_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            stack_mem[wr_addr] <= ch_reg;
            top_reg            <= ch_reg;
            below_reg          <= top_reg;
        end
        else if (cmd.pop)
        begin
            top_reg   <= below_reg;
            below_reg <= stack_mem[rd_addr];
        end
    end

    always_comb
    begin
        sts.is_end     = end_reg;
        sts.is_letter  = letter_of(ch_reg);
        sts.is_lpar    = (ch_reg == CH_LPAR);
        sts.is_rpar    = (ch_reg == CH_RPAR);
        sts.empty      = (count_reg == '0);
        sts.one        = (count_reg == COUNT_W'(1));
        sts.top_lpar   = (top_reg == CH_LPAR);
        sts.below_lpar = (below_reg == CH_LPAR);
        sts.pops_top   = (prec_of(ch_reg) <= prec_of(top_reg));
        sts.pops_below = (prec_of(ch_reg) <= prec_of(below_reg));
        sts.out_free   = !out_valid_reg || !post_stall;
    end

    always_comb
    begin
        emit_data.end_marker = 1'b0;
        emit_data.last       = cmd.emit_last;
        case (cmd.emit_src)
            SRC_TOP:  emit_data.out_char = top_reg;
            SRC_CHAR: emit_data.out_char = ch_reg;
            SRC_TERM:
            begin
                emit_data.out_char   = CH_NUL;
                emit_data.end_marker = 1'b1;
            end
            default:  emit_data.out_char = top_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!post_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            out_data_reg <= emit_data;
    end

    assign post_valid = out_valid_reg;
    assign post_data  = out_data_reg;

endmodule

`default_nettype wire

@@ hdl/infix_to_postfix_converter.sv @@
// Infix-to-postfix converter top level (shunting-yard with an operator stack).
// Depends on itp_pkg, itp_ctrl and itp_dpath.
//
// Usage:
//   Input channel char_*: one expression byte per transfer (char_data.ch), or
//   an end item (char_data.is_end) that flushes the stack and emits a
//   terminator. Output channel post_*: one postfix byte per transfer; the
//   terminator has out_char zero and end_marker set; last marks the final
//   result caused by an input item. Items such as '(' cause no result.
//   A letter is captured in the input latch, and the evaluate state then
//   writes its result to the output register, which drives post_*.
//   One item is handled at a time: the controller latches it, then pops
//   operators to the output where the item calls for it (operators, ')' and
//   end flush); the stack gives up one entry per cycle while the output
//   register is free, and a stalled output register holds this up.
//   A result waits in the output register while post_stall is high; the
//   controller holds in its evaluate state (char_stall high) until the
//   register frees up, so nothing is lost or repeated.
//   Reset (rst_n low, asynchronous) empties the stack and the output register.
//   A push onto a full stack of STACK_DEPTH entries is dropped.
`default_nettype none

module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              char_valid,
    output logic                   char_stall,
    input  wire itp_pkg::itp_in_t  char_data,
    output logic                   post_valid,
    input  wire logic              post_stall,
    output itp_pkg::itp_out_t      post_data
);
    import itp_pkg::*;

    itp_cmd_t    cmd;
    itp_status_t sts;

    itp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    itp_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_data  (char_data),
        .cmd        (cmd),
        .sts        (sts),
        .post_valid (post_valid),
        .post_stall (post_stall),
        .post_data  (post_data)
    );

endmodule

`default_nettype wire
